>>> rtl/core/dccpwg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccpwg_pkg
// Shared types and constants for the DCC packet waveform generator.
// ----------------------------------------------------------------------------
package dccpwg_pkg;

    localparam int CFG_DUR_W = 20;
    localparam int CFG_PRE_W = 6;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // load status codes
    localparam logic [1:0] LOAD_NONE    = 2'd0;
    localparam logic [1:0] LOAD_OK      = 2'd1;
    localparam logic [1:0] LOAD_REFUSED = 2'd2;

    // register indexes
    localparam logic [2:0] REG_ZERO_HALF = 3'd0;
    localparam logic [2:0] REG_ONE_HALF  = 3'd1;
    localparam logic [2:0] REG_PREAMBLE  = 3'd2;
    localparam logic [2:0] REG_LEAD      = 3'd3;
    localparam logic [2:0] REG_GUARD     = 3'd4;
    localparam logic [2:0] REG_WINDOW    = 3'd5;
    localparam logic [2:0] REG_TAIL      = 3'd6;

    // register reset values
    localparam logic [CFG_DUR_W-1:0] ZERO_HALF_RST = 20'd20000;
    localparam logic [CFG_DUR_W-1:0] ONE_HALF_RST  = 20'd11600;
    localparam logic [CFG_PRE_W-1:0] PREAMBLE_RST  = 6'd12;
    localparam logic [CFG_DUR_W-1:0] LEAD_RST      = 20'd4800;
    localparam logic [CFG_DUR_W-1:0] GUARD_RST     = 20'd900;
    localparam logic [CFG_DUR_W-1:0] WINDOW_RST    = 20'd86600;
    localparam logic [CFG_DUR_W-1:0] TAIL_RST      = 20'd9400;

    // reset packet is 00 00 00, idle packet FF 00 FF, both three bytes
    localparam logic [7:0] RESET_PKT_BYTE = 8'h00;
    localparam logic [3:0] FIXED_PKT_LEN  = 4'd3;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic       dcc_level;
        logic       rail_power_level;
        logic       cutout_gap_level;
        logic [1:0] load_status;
    } out_t;

    typedef struct packed {
        logic [CFG_DUR_W-1:0] zero_half_ticks;
        logic [CFG_DUR_W-1:0] one_half_ticks;
        logic [CFG_PRE_W-1:0] preamble_count;
        logic [CFG_DUR_W-1:0] cutout_lead_ticks;
        logic [CFG_DUR_W-1:0] cutout_guard_ticks;
        logic [CFG_DUR_W-1:0] cutout_window_ticks;
        logic [CFG_DUR_W-1:0] cutout_tail_ticks;
    } cfg_t;

    typedef struct packed {
        logic dcc;
        logic power;
        logic gap;
    } pins_t;

    function automatic logic [7:0] idle_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hFF;
            2'd1:    b = 8'h00;
            2'd2:    b = 8'hFF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/core/dcc_packet_waveform_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_packet_waveform_generator
// DCC track signal generator with cutout timing, one request per clock while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid / in_stall / in_data): each request is either a
//   load of one packet byte or one timer tick. Loads fill a pending packet
//   until a byte flagged last (or a full buffer) completes it; a load while
//   a completed packet still waits is refused. Ticks step the waveform.
//   out channel (out_valid / out_stall / out_data): exactly one result per
//   request, carrying the pin levels after that request and the load status.
//   out_valid rises in the cycle after acceptance. A new request can be
//   taken every cycle unless in_stall is up; the pins, timer and packet
//   store all update in the same cycle the request is accepted, then the
//   result sits in the output register. While the receiver stalls with a
//   result held, in_stall is raised and nothing new is accepted; the held
//   result does not change. After reset the settings hold their defaults,
//   the reset packet 00 00 00 is sent first, then a completed pending packet
//   or the idle packet FF 00 FF follows each cutout. The user must write
//   settings over APB only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module dcc_packet_waveform_generator #(
    parameter int MAX_PACKET_BYTES = 8,
    parameter int DURATION_BITS    = 20
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  dccpwg_pkg::in_t                in_data,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output dccpwg_pkg::out_t               out_data,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dccpwg_pkg::APB_AW-1:0]  paddr,
    input  logic [dccpwg_pkg::APB_DW-1:0]  pwdata,
    output logic [dccpwg_pkg::APB_DW-1:0]  prdata,
    output logic                           pready
);

    localparam int IDXW = $clog2(MAX_PACKET_BYTES);
    localparam int LENW = $clog2(MAX_PACKET_BYTES + 1);

    dccpwg_pkg::cfg_t  cfg;
    dccpwg_pkg::pins_t pins_next;
    dccpwg_pkg::out_t  out_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              load_en;
    logic              tick_en;
    logic [1:0]        load_status;
    logic              latch_pkt;
    logic [IDXW-1:0]   rd_idx;
    logic [7:0]        rd_byte;
    logic [LENW-1:0]   act_len;

    assign pready = 1'b1;

    // hold off new requests only while a finished result is being stalled
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign load_en  = accept && (in_data.operation == dccpwg_pkg::OP_LOAD);
    assign tick_en  = accept && (in_data.operation == dccpwg_pkg::OP_TICK);

    dccpwg_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    dccpwg_pkt_buf #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_pkt_buf
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_en     (load_en),
        .load_byte   (in_data.data_byte),
        .load_last   (in_data.last_byte),
        .load_status (load_status),
        .latch_pkt   (latch_pkt),
        .rd_idx      (rd_idx),
        .rd_byte     (rd_byte),
        .act_len     (act_len)
    );

    dccpwg_wave_seq #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .DURATION_BITS    (DURATION_BITS)
    ) u_wave_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_en   (tick_en),
        .cfg       (cfg),
        .latch_pkt (latch_pkt),
        .rd_idx    (rd_idx),
        .rd_byte   (rd_byte),
        .act_len   (act_len),
        .pins_next (pins_next)
    );

    // output register: full when a result has not yet been taken
    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.dcc_level        <= pins_next.dcc;
            out_data_reg.rail_power_level <= pins_next.power;
            out_data_reg.cutout_gap_level <= pins_next.gap;
            out_data_reg.load_status      <= load_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/core/dccpwg_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccpwg_cfg_regs
// APB register bank holding bit timing and cutout timing settings.
// ----------------------------------------------------------------------------
module dccpwg_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dccpwg_pkg::APB_AW-1:0]  paddr,
    input  logic [dccpwg_pkg::APB_DW-1:0]  pwdata,
    output logic [dccpwg_pkg::APB_DW-1:0]  prdata,
    output dccpwg_pkg::cfg_t               cfg
);

    dccpwg_pkg::cfg_t cfg_reg;
    logic [2:0]       idx;
    logic             wr_en;

    assign idx   = paddr[4:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_half_ticks     <= dccpwg_pkg::ZERO_HALF_RST;
            cfg_reg.one_half_ticks      <= dccpwg_pkg::ONE_HALF_RST;
            cfg_reg.preamble_count      <= dccpwg_pkg::PREAMBLE_RST;
            cfg_reg.cutout_lead_ticks   <= dccpwg_pkg::LEAD_RST;
            cfg_reg.cutout_guard_ticks  <= dccpwg_pkg::GUARD_RST;
            cfg_reg.cutout_window_ticks <= dccpwg_pkg::WINDOW_RST;
            cfg_reg.cutout_tail_ticks   <= dccpwg_pkg::TAIL_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                dccpwg_pkg::REG_ZERO_HALF:
                    cfg_reg.zero_half_ticks <= pwdata[dccpwg_pkg::CFG_DUR_W-1:0];
                dccpwg_pkg::REG_ONE_HALF:
                    cfg_reg.one_half_ticks <= pwdata[dccpwg_pkg::CFG_DUR_W-1:0];
                dccpwg_pkg::REG_PREAMBLE:
                    cfg_reg.preamble_count <= pwdata[dccpwg_pkg::CFG_PRE_W-1:0];
                dccpwg_pkg::REG_LEAD:
                    cfg_reg.cutout_lead_ticks <= pwdata[dccpwg_pkg::CFG_DUR_W-1:0];
                dccpwg_pkg::REG_GUARD:
                    cfg_reg.cutout_guard_ticks <= pwdata[dccpwg_pkg::CFG_DUR_W-1:0];
                dccpwg_pkg::REG_WINDOW:
                    cfg_reg.cutout_window_ticks <= pwdata[dccpwg_pkg::CFG_DUR_W-1:0];
                dccpwg_pkg::REG_TAIL:
                    cfg_reg.cutout_tail_ticks <= pwdata[dccpwg_pkg::CFG_DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            dccpwg_pkg::REG_ZERO_HALF: prdata = 32'(cfg_reg.zero_half_ticks);
            dccpwg_pkg::REG_ONE_HALF:  prdata = 32'(cfg_reg.one_half_ticks);
            dccpwg_pkg::REG_PREAMBLE:  prdata = 32'(cfg_reg.preamble_count);
            dccpwg_pkg::REG_LEAD:      prdata = 32'(cfg_reg.cutout_lead_ticks);
            dccpwg_pkg::REG_GUARD:     prdata = 32'(cfg_reg.cutout_guard_ticks);
            dccpwg_pkg::REG_WINDOW:    prdata = 32'(cfg_reg.cutout_window_ticks);
            dccpwg_pkg::REG_TAIL:      prdata = 32'(cfg_reg.cutout_tail_ticks);
            default:                   prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/dccpwg_pkt_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccpwg_pkt_buf
// Ping-pong packet store: one bank fills from loads, the other is on the line.
// ----------------------------------------------------------------------------
module dccpwg_pkt_buf #(
    parameter int MAX_PACKET_BYTES = 8
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   load_en,
    input  logic [7:0]                             load_byte,
    input  logic                                   load_last,
    output logic [1:0]                             load_status,
    input  logic                                   latch_pkt,
    input  logic [$clog2(MAX_PACKET_BYTES)-1:0]    rd_idx,
    output logic [7:0]                             rd_byte,
    output logic [$clog2(MAX_PACKET_BYTES+1)-1:0]  act_len
);

    localparam int IDXW = $clog2(MAX_PACKET_BYTES);
    localparam int LENW = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [LENW-1:0] MAX_LEN = LENW'(MAX_PACKET_BYTES);

    typedef enum logic [1:0] {
        KIND_RESET,
        KIND_IDLE,
        KIND_BUF
    } kind_t;

    logic [7:0]      mem [2][MAX_PACKET_BYTES];
    logic [LENW-1:0] pend_len_reg, pend_len_next;
    logic            pend_done_reg, pend_done_next;
    logic            act_sel_reg, act_sel_next;
    kind_t           act_kind_reg, act_kind_next;
    logic [LENW-1:0] act_len_reg, act_len_next;
    logic            wr_ok;
    logic [LENW-1:0] len_inc;

    assign len_inc = pend_len_reg + 1'b1;
    assign wr_ok   = load_en && !pend_done_reg && (pend_len_reg < MAX_LEN);
    assign act_len = act_len_reg;

    always_comb
    begin
        if (!load_en)
            load_status = dccpwg_pkg::LOAD_NONE;
        else if (wr_ok)
            load_status = dccpwg_pkg::LOAD_OK;
        else
            load_status = dccpwg_pkg::LOAD_REFUSED;
    end

    always_comb
    begin
        pend_len_next  = pend_len_reg;
        pend_done_next = pend_done_reg;
        act_sel_next   = act_sel_reg;
        act_kind_next  = act_kind_reg;
        act_len_next   = act_len_reg;
        if (latch_pkt)
        begin
            if (pend_done_reg)
            begin
                act_sel_next  = !act_sel_reg;
                act_kind_next = KIND_BUF;
                act_len_next  = pend_len_reg;
            end
            else
            begin
                act_kind_next = KIND_IDLE;
                act_len_next  = LENW'(dccpwg_pkg::FIXED_PKT_LEN);
            end
            pend_len_next  = '0;
            pend_done_next = 1'b0;
        end
        else if (wr_ok)
        begin
            pend_len_next  = len_inc;
            pend_done_next = load_last || (len_inc == MAX_LEN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_len_reg  <= '0;
            pend_done_reg <= 1'b0;
            act_sel_reg   <= 1'b0;
            act_kind_reg  <= KIND_RESET;
            act_len_reg   <= LENW'(dccpwg_pkg::FIXED_PKT_LEN);
        end
        else
        begin
            pend_len_reg  <= pend_len_next;
            pend_done_reg <= pend_done_next;
            act_sel_reg   <= act_sel_next;
            act_kind_reg  <= act_kind_next;
            act_len_reg   <= act_len_next;
        end
    end

    // the filling bank is always the one not on the line
    always_ff @(posedge clk)
    begin
        if (wr_ok)
            mem[!act_sel_reg][pend_len_reg[IDXW-1:0]] <= load_byte;
    end

    always_comb
    begin
        case (act_kind_reg)
            KIND_IDLE: rd_byte = dccpwg_pkg::idle_byte(rd_idx[1:0]);
            KIND_BUF:  rd_byte = mem[act_sel_reg][rd_idx];
            default:   rd_byte = dccpwg_pkg::RESET_PKT_BYTE;
        endcase
    end

endmodule

>>> rtl/core/dccpwg_wave_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccpwg_wave_seq
// Segment timer and bit/cutout sequencer driving the three line pins.
// ----------------------------------------------------------------------------
module dccpwg_wave_seq #(
    parameter int MAX_PACKET_BYTES = 8,
    parameter int DURATION_BITS    = 20
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   tick_en,
    input  dccpwg_pkg::cfg_t                       cfg,
    output logic                                   latch_pkt,
    output logic [$clog2(MAX_PACKET_BYTES)-1:0]    rd_idx,
    input  logic [7:0]                             rd_byte,
    input  logic [$clog2(MAX_PACKET_BYTES+1)-1:0]  act_len,
    output dccpwg_pkg::pins_t                      pins_next
);

    localparam int IDXW = $clog2(MAX_PACKET_BYTES);
    localparam int LENW = $clog2(MAX_PACKET_BYTES + 1);

    typedef enum logic [3:0] {
        PH_PREAMBLE,
        PH_START,
        PH_DATA,
        PH_END,
        PH_CUT0,
        PH_CUT1,
        PH_CUT2,
        PH_CUT3,
        PH_CUT4,
        PH_CUT5,
        PH_CUT6,
        PH_CUT7
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [dccpwg_pkg::CFG_PRE_W-1:0] pre_left_reg, pre_left_next;
    logic [LENW-1:0]                 byte_pos_reg, byte_pos_next;
    logic [2:0]                      bit_pos_reg, bit_pos_next;
    logic                            second_half_reg, second_half_next;
    logic [DURATION_BITS-1:0]        ticks_reg, ticks_next;
    dccpwg_pkg::pins_t               pins_reg;
    logic [dccpwg_pkg::CFG_DUR_W-1:0] dur_sel;
    logic [DURATION_BITS-1:0]        dur;
    logic                            bit_val;
    logic [LENW-1:0]                 byte_inc;

    assign rd_idx   = byte_pos_reg[IDXW-1:0];
    assign byte_inc = byte_pos_reg + 1'b1;

    always_comb
    begin
        case (phase_reg)
            PH_START: bit_val = 1'b0;
            PH_DATA:  bit_val = rd_byte[~bit_pos_reg];   // MSB first
            default:  bit_val = 1'b1;
        endcase
    end

    always_comb
    begin
        phase_next       = phase_reg;
        pre_left_next    = pre_left_reg;
        byte_pos_next    = byte_pos_reg;
        bit_pos_next     = bit_pos_reg;
        second_half_next = second_half_reg;
        ticks_next       = ticks_reg;
        pins_next        = pins_reg;
        latch_pkt        = 1'b0;
        dur_sel          = cfg.one_half_ticks;
        dur              = '0;
        if (tick_en)
        begin
            if (ticks_reg == '0)
            begin
                unique case (phase_reg) inside
                    PH_PREAMBLE, PH_START, PH_DATA, PH_END:
                    begin
                        dur_sel       = bit_val ? cfg.one_half_ticks : cfg.zero_half_ticks;
                        pins_next.dcc = !second_half_reg;
                        if (!second_half_reg)
                            second_half_next = 1'b1;
                        else
                        begin
                            second_half_next = 1'b0;
                            case (phase_reg)
                                PH_PREAMBLE:
                                begin
                                    if (pre_left_reg <= 6'd1)
                                    begin
                                        pre_left_next = '0;
                                        byte_pos_next = '0;
                                        phase_next    = PH_START;
                                    end
                                    else
                                        pre_left_next = pre_left_reg - 1'b1;
                                end
                                PH_START:
                                begin
                                    bit_pos_next = '0;
                                    phase_next   = PH_DATA;
                                end
                                PH_DATA:
                                begin
                                    bit_pos_next = bit_pos_reg + 1'b1;
                                    if (bit_pos_reg == 3'd7)
                                    begin
                                        byte_pos_next = byte_inc;
                                        phase_next    = (byte_inc >= act_len) ? PH_END : PH_START;
                                    end
                                end
                                default: phase_next = PH_CUT0;
                            endcase
                        end
                    end
                    PH_CUT0:
                    begin
                        pins_next.dcc = 1'b1;
                        dur_sel       = cfg.cutout_lead_ticks;
                        phase_next    = PH_CUT1;
                    end
                    PH_CUT1:
                    begin
                        pins_next.power = 1'b0;
                        dur_sel         = cfg.cutout_guard_ticks;
                        phase_next      = PH_CUT2;
                    end
                    PH_CUT2:
                    begin
                        pins_next.gap = 1'b1;
                        dur_sel       = cfg.cutout_guard_ticks;
                        phase_next    = PH_CUT3;
                    end
                    PH_CUT3:
                    begin
                        pins_next.power = 1'b1;
                        dur_sel         = cfg.cutout_window_ticks;
                        phase_next      = PH_CUT4;
                    end
                    PH_CUT4:
                    begin
                        pins_next.power = 1'b0;
                        dur_sel         = cfg.cutout_guard_ticks;
                        phase_next      = PH_CUT5;
                    end
                    PH_CUT5:
                    begin
                        pins_next.gap = 1'b0;
                        dur_sel       = cfg.cutout_guard_ticks;
                        phase_next    = PH_CUT6;
                    end
                    PH_CUT6:
                    begin
                        pins_next.power = 1'b1;
                        dur_sel         = cfg.cutout_tail_ticks;
                        phase_next      = PH_CUT7;
                    end
                    default:
                    begin
                        // last cutout step, then the next packet goes on the line
                        pins_next.dcc    = 1'b0;
                        dur_sel          = cfg.one_half_ticks;
                        latch_pkt        = 1'b1;
                        phase_next       = PH_PREAMBLE;
                        pre_left_next    = cfg.preamble_count;
                        byte_pos_next    = '0;
                        bit_pos_next     = '0;
                        second_half_next = 1'b0;
                    end
                endcase
                dur = DURATION_BITS'(dur_sel);
                // a zero duration behaves as one tick
                ticks_next = (dur == '0) ? '0 : dur - 1'b1;
            end
            else
                ticks_next = ticks_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_PREAMBLE;
            pre_left_reg    <= dccpwg_pkg::PREAMBLE_RST;
            byte_pos_reg    <= '0;
            bit_pos_reg     <= '0;
            second_half_reg <= 1'b0;
            ticks_reg       <= '0;
            pins_reg        <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            pre_left_reg    <= pre_left_next;
            byte_pos_reg    <= byte_pos_next;
            bit_pos_reg     <= bit_pos_next;
            second_half_reg <= second_half_next;
            ticks_reg       <= ticks_next;
            pins_reg        <= pins_next;
        end
    end

endmodule
